// ===== hdl/pqrt_pkg.sv =====
package pqrt_pkg;

   // Default table geometry
   localparam int SLOTS_DEF   = 32;
   localparam int ID_BITS_DEF = 16;

   // Fixed field widths
   localparam int OP_W      = 2;
   localparam int QID_W     = 16;
   localparam int KIND_W    = 3;
   localparam int RID_W     = 16;
   localparam int SLOT_W    = 5;
   localparam int TRIES_W   = 4;
   localparam int LIMIT_W   = 4;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd4;
   localparam logic [TRIES_W-1:0] TRIES_MAX   = 4'd15;
   localparam logic [TRIES_W-1:0] TRIES_FIRST = 4'd1;

   typedef enum logic [OP_W-1:0] {
      OP_SEND = 2'd0,
      OP_RESP = 2'd1,
      OP_TICK = 2'd2
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      K_ACCEPTED   = 3'd0,
      K_FULL       = 3'd1,
      K_MATCHED    = 3'd2,
      K_UNKNOWN    = 3'd3,
      K_RETRANSMIT = 3'd4,
      K_TIMEOUT    = 3'd5,
      K_IDLE       = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVAL,
      ST_FINISH
   } state_type;

endpackage

// ===== hdl/pqrt_req_if.sv =====
interface pqrt_req_if;
   logic                        valid;
   logic                        ready;
   logic [pqrt_pkg::OP_W-1:0]   op;
   logic [pqrt_pkg::QID_W-1:0]  query_id;

   modport source (output valid, output op, output query_id, input ready);
   modport sink   (input valid, input op, input query_id, output ready);
endinterface

// ===== hdl/pqrt_rsp_if.sv =====
interface pqrt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pqrt_pkg::KIND_W-1:0]  kind;
   logic [pqrt_pkg::RID_W-1:0]   result_id;
   logic [pqrt_pkg::SLOT_W-1:0]  slot;
   logic                         last;

   modport source (output valid, output kind, output result_id, output slot, output last,
                   input ready);
   modport sink   (input valid, input kind, input result_id, input slot, input last,
                   output ready);
endinterface

// ===== hdl/pending_query_retry_table.sv =====
// Channel   Direction  Handshake     Payload
// req_if    in         valid/ready   op[1:0], query_id[15:0]
// rsp_if    out        valid/ready   kind[2:0], result_id[15:0], slot[4:0], last
// csr_*     in         write enable  csr_wr_data[3:0] = retry_limit
//
// One sequencer walks the table one slot a cycle while rsp_if does not stall, through
// a single compare unit; a slot that needs its stored id or tries takes an extra
// evaluate state for the registered memory read. A send stops at the lowest free
// slot, else reports full; a response stops at its id; a tick walks the whole table.
// req_if.ready is high only between items. Synchronous reset clears the valid bits,
// no clearing pass. A stalled rsp_if holds the walk at the next result; one result
// register and one held tick result part the walk from the output.
module pending_query_retry_table #(
   parameter int SLOTS   = pqrt_pkg::SLOTS_DEF,
   parameter int ID_BITS = pqrt_pkg::ID_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   pqrt_req_if.sink                        req_if,
   pqrt_rsp_if.source                      rsp_if,
   input  logic                            csr_wr_en,
   input  logic [pqrt_pkg::LIMIT_W-1:0]    csr_wr_data
);
   import pqrt_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   // Sequencer and item registers
   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [QID_W-1:0]       qid_ff, qid_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [SLOTS-1:0]       valid_ff, valid_in;
   logic [ID_BITS-1:0]     next_id_ff, next_id_in;
   logic [LIMIT_W-1:0]     limit_ff;

   // Table memory and its registered read
   logic [ID_BITS-1:0]     id_mem [SLOTS];
   logic [TRIES_W-1:0]     tries_mem [SLOTS];
   logic [ID_BITS-1:0]     rd_id_ff;
   logic [TRIES_W-1:0]     rd_tries_ff;
   logic                   id_we, tries_we;
   logic [TRIES_W-1:0]     tries_wd;

   // Held tick result, waiting to learn whether it is the final one
   logic                   held_vld_ff, held_vld_in;
   kind_type               held_kind_ff, held_kind_in;
   logic [RID_W-1:0]       held_id_ff, held_id_in;
   logic [SLOT_W-1:0]      held_slot_ff, held_slot_in;

   // Result register
   logic                   rsp_vld_ff, rsp_vld_in;
   kind_type               rsp_kind_ff, rsp_kind_in;
   logic [RID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic [SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Shared compare unit and helpers
   logic                   req_take, out_free, slot_v, scan_hit, at_end;
   logic                   id_match, expired, eval_need_out, eval_go;
   logic [31:0]            qid_wide, idx_wide, rd_id_wide, next_id_wide;
   logic [ID_BITS-1:0]     qid_key;
   logic [SLOT_W-1:0]      cur_slot;

   assign req_if.ready     = (state_ff == ST_IDLE);
   assign req_take         = req_if.valid && req_if.ready;
   assign out_free         = !rsp_vld_ff || rsp_if.ready;

   assign qid_wide         = {16'd0, qid_ff};
   assign qid_key          = qid_wide[ID_BITS-1:0];
   assign idx_wide         = 32'(idx_ff);
   assign cur_slot         = idx_wide[SLOT_W-1:0];
   assign rd_id_wide       = 32'(rd_id_ff);
   assign next_id_wide     = 32'(next_id_ff);

   assign slot_v           = valid_ff[idx_ff];
   assign scan_hit         = (op_ff == OP_SEND) ? !slot_v : slot_v;
   assign at_end           = (idx_ff == LAST_IDX);
   assign id_match         = (rd_id_ff == qid_key);
   assign expired          = (rd_tries_ff >= limit_ff);

   always_comb begin
      unique case (op_ff)
         OP_SEND: eval_need_out = 1'b1;
         OP_RESP: eval_need_out = id_match;
         default: eval_need_out = held_vld_ff;
      endcase
   end
   assign eval_go = !eval_need_out || out_free;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_if.op == OP_SEND || req_if.op == OP_RESP ||
                             req_if.op == OP_TICK)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_hit) begin
               state_in = ST_EVAL;
            end else if (at_end) begin
               state_in = ST_FINISH;
            end
         end
         ST_EVAL: begin
            if (eval_go) begin
               if (op_ff == OP_SEND || (op_ff == OP_RESP && id_match)) begin
                  state_in = ST_IDLE;
               end else if (at_end) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and result generation
   always_comb begin
      op_in        = op_ff;
      qid_in       = qid_ff;
      idx_in       = idx_ff;
      valid_in     = valid_ff;
      next_id_in   = next_id_ff;
      id_we        = 1'b0;
      tries_we     = 1'b0;
      tries_wd     = TRIES_FIRST;
      held_vld_in  = held_vld_ff;
      held_kind_in = held_kind_ff;
      held_id_in   = held_id_ff;
      held_slot_in = held_slot_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_if.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               op_in       = op_type'(req_if.op);
               qid_in      = req_if.query_id;
               idx_in      = '0;
               held_vld_in = 1'b0;
            end
         end
         ST_SCAN: begin
            // skip slots that do not qualify
            if (!scan_hit && !at_end) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_EVAL: begin
            if (eval_go) begin
               unique case (op_ff)
                  OP_SEND: begin
                     rsp_vld_in       = 1'b1;
                     rsp_kind_in      = K_ACCEPTED;
                     rsp_id_in        = next_id_wide[RID_W-1:0];
                     rsp_slot_in      = cur_slot;
                     rsp_last_in      = 1'b1;
                     valid_in[idx_ff] = 1'b1;
                     id_we            = 1'b1;
                     tries_we         = 1'b1;
                     tries_wd         = TRIES_FIRST;
                     next_id_in       = next_id_ff + ID_BITS'(1);
                  end
                  OP_RESP: begin
                     if (id_match) begin
                        rsp_vld_in       = 1'b1;
                        rsp_kind_in      = K_MATCHED;
                        rsp_id_in        = rd_id_wide[RID_W-1:0];
                        rsp_slot_in      = cur_slot;
                        rsp_last_in      = 1'b1;
                        valid_in[idx_ff] = 1'b0;
                     end else if (!at_end) begin
                        idx_in = idx_ff + IDX_W'(1);
                     end
                  end
                  default: begin
                     // release the previous tick result, hold this one
                     if (held_vld_ff) begin
                        rsp_vld_in  = 1'b1;
                        rsp_kind_in = held_kind_ff;
                        rsp_id_in   = held_id_ff;
                        rsp_slot_in = held_slot_ff;
                        rsp_last_in = 1'b0;
                     end
                     held_vld_in  = 1'b1;
                     held_id_in   = rd_id_wide[RID_W-1:0];
                     held_slot_in = cur_slot;
                     if (expired) begin
                        held_kind_in     = K_TIMEOUT;
                        valid_in[idx_ff] = 1'b0;
                     end else begin
                        held_kind_in = K_RETRANSMIT;
                        tries_we     = 1'b1;
                        tries_wd     = (rd_tries_ff < TRIES_MAX) ?
                                       rd_tries_ff + TRIES_W'(1) : rd_tries_ff;
                     end
                     if (!at_end) begin
                        idx_in = idx_ff + IDX_W'(1);
                     end
                  end
               endcase
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_last_in = 1'b1;
               held_vld_in = 1'b0;
               unique case (op_ff)
                  OP_SEND: begin
                     rsp_kind_in = K_FULL;
                     rsp_id_in   = '0;
                     rsp_slot_in = '0;
                  end
                  OP_RESP: begin
                     rsp_kind_in = K_UNKNOWN;
                     rsp_id_in   = qid_ff;
                     rsp_slot_in = '0;
                  end
                  default: begin
                     if (held_vld_ff) begin
                        rsp_kind_in = held_kind_ff;
                        rsp_id_in   = held_id_ff;
                        rsp_slot_in = held_slot_ff;
                     end else begin
                        rsp_kind_in = K_IDLE;
                        rsp_id_in   = '0;
                        rsp_slot_in = '0;
                     end
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         valid_ff    <= '0;
         next_id_ff  <= ID_BITS'(1);
         limit_ff    <= LIMIT_RESET;
         held_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         next_id_ff  <= next_id_in;
         held_vld_ff <= held_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      qid_ff       <= qid_in;
      idx_ff       <= idx_in;
      held_kind_ff <= held_kind_in;
      held_id_ff   <= held_id_in;
      held_slot_ff <= held_slot_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Table memory: one write and one registered read at the walk index
   always_ff @(posedge clock) begin
      if (id_we) begin
         id_mem[idx_ff] <= next_id_ff;
      end
      if (tries_we) begin
         tries_mem[idx_ff] <= tries_wd;
      end
      rd_id_ff    <= id_mem[idx_ff];
      rd_tries_ff <= tries_mem[idx_ff];
   end

   assign rsp_if.valid     = rsp_vld_ff;
   assign rsp_if.kind      = rsp_kind_ff;
   assign rsp_if.result_id = rsp_id_ff;
   assign rsp_if.slot      = rsp_slot_ff;
   assign rsp_if.last      = rsp_last_ff;

endmodule

// ===== hdl/pqrt_checker.sv =====
module pqrt_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [pqrt_pkg::OP_W-1:0]       req_op,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [pqrt_pkg::KIND_W-1:0]     rsp_kind,
   input  logic [pqrt_pkg::RID_W-1:0]      rsp_result_id,
   input  logic [pqrt_pkg::SLOT_W-1:0]     rsp_slot,
   input  logic                            rsp_last
);
   import pqrt_pkg::*;

   // Hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_result_id) && $stable(rsp_slot) && $stable(rsp_last))
      else $error("stalled result transaction changed");

   // Single-result kinds always close their item
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == K_ACCEPTED || rsp_kind == K_FULL ||
      rsp_kind == K_MATCHED || rsp_kind == K_UNKNOWN || rsp_kind == K_IDLE) |-> rsp_last)
      else $error("single-result kind without last");

   // Full table and idle tick concern no slot
   a_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == K_FULL || rsp_kind == K_IDLE) |->
      rsp_result_id == '0 && rsp_slot == '0)
      else $error("full or idle result carries an id or slot");

   // An accepted working item blocks the next request
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_SEND || req_op == OP_RESP ||
      req_op == OP_TICK) |=> !req_ready)
      else $error("request taken while an item is in progress");

endmodule

bind pending_query_retry_table pqrt_checker u_pqrt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .req_op        (req_if.op),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_kind      (rsp_if.kind),
   .rsp_result_id (rsp_if.result_id),
   .rsp_slot      (rsp_if.slot),
   .rsp_last      (rsp_if.last)
);

// ===== test/pending_query_retry_table_tb.sv =====
`timescale 1ns / 100ps

module pending_query_retry_table_tb;
   import pqrt_pkg::*;

   localparam int SLOTS = SLOTS_DEF;
   // The unused op code: the block ignores it
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   // Quiet cycles before a limit write and at the end: longer than the
   // slowest item (a response walk over the whole table)
   localparam int SETTLE = 2 * SLOTS + 16;
   // Cycles with no transaction at all before the run is abandoned: a drain,
   // the settle time, a full walk, a stall and a gap, taken many times over
   localparam int WATCH_LIMIT = 4000;

   typedef struct {
      kind_type          kind;
      logic [RID_W-1:0]  rid;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } table_result_type;

   typedef enum logic [1:0] {
      ACT_ITEM,
      ACT_LIVE_RESP,
      ACT_CFG,
      ACT_DRAIN
   } step_act_type;

   typedef struct {
      step_act_type       act;
      logic [OP_W-1:0]    op;
      logic [QID_W-1:0]   qid;
      logic [LIMIT_W-1:0] limit;
   } stim_step_type;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [LIMIT_W-1:0]  csr_wr_data;

   pqrt_req_if req_ch ();
   pqrt_rsp_if rsp_ch ();

   // Shadow of the table, the id counter and the limit register
   logic                tbl_valid [SLOTS];
   logic [RID_W-1:0]    tbl_id    [SLOTS];
   logic [TRIES_W-1:0]  tbl_tries [SLOTS];
   logic [RID_W-1:0]    id_next;
   logic [LIMIT_W-1:0]  limit_model;

   table_result_type    awaited_results [$];
   stim_step_type       script_q [$];

   int                  send_gap;
   int                  rsp_hold;
   int                  quiet_cycles;
   int                  idle_watch;
   int                  check_errors;
   bit                  drv_calm;
   bit                  rcv_calm;

   pending_query_retry_table DUT (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap(bit calm);
      return calm ? 0 : int'($urandom_range(0, 4));
   endfunction

   function automatic void queue_step(step_act_type act, logic [OP_W-1:0] op,
                                      logic [QID_W-1:0] qid, logic [LIMIT_W-1:0] limit);
      stim_step_type s;
      s.act   = act;
      s.op    = op;
      s.qid   = qid;
      s.limit = limit;
      script_q.push_back(s);
   endfunction

   // Advance the shadow table by one request and queue the results it causes
   function automatic void apply_table_op(logic [OP_W-1:0] op, logic [QID_W-1:0] qid);
      table_result_type batch [$];
      int               hit;
      hit = -1;
      case (op)
         OP_SEND: begin
            for (int s = SLOTS - 1; s >= 0; s--)
               if (!tbl_valid[s]) hit = s;
            if (hit < 0) begin
               batch.push_back('{K_FULL, '0, '0, 1'b0});
            end else begin
               tbl_valid[hit] = 1'b1;
               tbl_id[hit]    = id_next;
               tbl_tries[hit] = TRIES_FIRST;
               batch.push_back('{K_ACCEPTED, id_next, SLOT_W'(hit), 1'b0});
               id_next = id_next + 1'b1;
            end
         end
         OP_RESP: begin
            for (int s = SLOTS - 1; s >= 0; s--)
               if (tbl_valid[s] && tbl_id[s] == qid) hit = s;
            if (hit < 0) begin
               batch.push_back('{K_UNKNOWN, qid, '0, 1'b0});
            end else begin
               batch.push_back('{K_MATCHED, tbl_id[hit], SLOT_W'(hit), 1'b0});
               tbl_valid[hit] = 1'b0;
               tbl_id[hit]    = '0;
               tbl_tries[hit] = '0;
            end
         end
         OP_TICK: begin
            for (int s = 0; s < SLOTS; s++) begin
               if (tbl_valid[s]) begin
                  if (tbl_tries[s] >= limit_model) begin
                     batch.push_back('{K_TIMEOUT, tbl_id[s], SLOT_W'(s), 1'b0});
                     tbl_valid[s] = 1'b0;
                     tbl_id[s]    = '0;
                     tbl_tries[s] = '0;
                  end else begin
                     batch.push_back('{K_RETRANSMIT, tbl_id[s], SLOT_W'(s), 1'b0});
                     if (tbl_tries[s] < TRIES_MAX) tbl_tries[s] = tbl_tries[s] + 1'b1;
                  end
               end
            end
            if (batch.size() == 0) batch.push_back('{K_IDLE, '0, '0, 1'b0});
         end
         default: ;
      endcase
      if (batch.size() != 0) begin
         batch[batch.size() - 1].last = 1'b1;
         foreach (batch[i]) awaited_results.push_back(batch[i]);
      end
   endfunction

   // Request driver: present queued steps, write the limit once the block is quiet
   always @(posedge clock) begin
      stim_step_type    step;
      logic             keep_valid;
      logic             write_limit;
      logic [QID_W-1:0] target;
      int               start;
      bit               found;
      if (reset) begin
         req_ch.valid <= 1'b0;
         csr_wr_en    <= 1'b0;
         send_gap     <= 0;
      end else begin
         keep_valid  = req_ch.valid && !req_ch.ready;
         write_limit = 1'b0;
         if (req_ch.valid) begin
            // hold until the transaction goes; start nothing on its edge
            if (req_ch.ready) begin
               send_gap <= pick_gap(drv_calm);
               if ($urandom_range(0, 24) == 0) drv_calm <= !drv_calm;
            end
         end else if (send_gap != 0) begin
            send_gap <= send_gap - 1;
         end else if (script_q.size() != 0) begin
            step = script_q[0];
            case (step.act)
               ACT_ITEM: begin
                  req_ch.op       <= step.op;
                  req_ch.query_id <= step.qid;
                  keep_valid      = 1'b1;
               end
               ACT_LIVE_RESP: begin
                  // answer an outstanding id, else fall back to the random one
                  target = step.qid;
                  found  = 1'b0;
                  start  = $urandom_range(0, SLOTS - 1);
                  for (int k = 0; k < SLOTS; k++) begin
                     if (!found && tbl_valid[(start + k) % SLOTS]) begin
                        target = tbl_id[(start + k) % SLOTS];
                        found  = 1'b1;
                     end
                  end
                  req_ch.op       <= OP_RESP;
                  req_ch.query_id <= target;
                  keep_valid      = 1'b1;
               end
               ACT_CFG: begin
                  if (quiet_cycles >= SETTLE) begin
                     csr_wr_data <= step.limit;
                     write_limit = 1'b1;
                  end
               end
               default: ;
            endcase
            if (keep_valid || write_limit || (step.act == ACT_DRAIN && quiet_cycles >= 1))
               void'(script_q.pop_front());
         end
         req_ch.valid <= keep_valid;
         csr_wr_en    <= write_limit;
      end
   end

   // Result monitor: predict on each request, check each result, stall at random
   always @(posedge clock) begin
      table_result_type want;
      int               hold;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold     <= 0;
         quiet_cycles <= 0;
         idle_watch   <= 0;
         limit_model  = LIMIT_RESET;
         id_next      = RID_W'(1);
         for (int s = 0; s < SLOTS; s++) begin
            tbl_valid[s] = 1'b0;
            tbl_id[s]    = '0;
            tbl_tries[s] = '0;
         end
      end else begin
         hold = rsp_hold;
         if (csr_wr_en) limit_model = csr_wr_data;
         if (req_ch.valid && req_ch.ready) apply_table_op(req_ch.op, req_ch.query_id);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_results.size() == 0) begin
               check_errors++;
               if (check_errors <= 10)
                  $display("%0t: unexpected result kind %0d id %h slot %0d last %b", $time,
                           rsp_ch.kind, rsp_ch.result_id, rsp_ch.slot, rsp_ch.last);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_ch.kind !== want.kind || rsp_ch.result_id !== want.rid ||
                   rsp_ch.slot !== want.slot || rsp_ch.last !== want.last) begin
                  check_errors++;
                  if (check_errors <= 10)
                     $display("%0t: expected kind %0d id %h slot %0d last %b, got %0d %h %0d %b",
                              $time, want.kind, want.rid, want.slot, want.last, rsp_ch.kind,
                              rsp_ch.result_id, rsp_ch.slot, rsp_ch.last);
               end
            end
            hold = pick_gap(rcv_calm);
            if ($urandom_range(0, 59) == 0) rcv_calm <= !rcv_calm;
         end else if (hold != 0) begin
            hold--;
         end
         rsp_hold     <= hold;
         rsp_ch.ready <= (hold == 0);

         // count cycles with nothing awaited and nothing offered
         if (awaited_results.size() == 0 && !req_ch.valid) quiet_cycles <= quiet_cycles + 1;
         else quiet_cycles <= 0;

         // abandon the run when no transaction moves for too long
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_wr_en) begin
            idle_watch <= 0;
         end else if (idle_watch >= WATCH_LIMIT) begin
            $display("pending_query_retry_table_tb failed");
            $finish;
         end else begin
            idle_watch <= idle_watch + 1;
         end
      end
   end

   initial begin
      logic [LIMIT_W-1:0] phase_limits [8];
      int                 r;
      int                 mix_len;
      bit                 burst;
      req_ch.valid    = 1'b0;
      req_ch.op       = OP_SEND;
      req_ch.query_id = '0;
      rsp_ch.ready    = 1'b0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = LIMIT_RESET;
      reset           = 1'b1;
      check_errors    = 0;
      drv_calm        = 1'b0;
      rcv_calm        = 1'b0;

      // Empty table: idle tick, unknown ids at both extremes, the unused op
      queue_step(ACT_ITEM, OP_TICK, 16'h0000, '0);
      queue_step(ACT_ITEM, OP_RESP, 16'h0000, '0);
      queue_step(ACT_ITEM, OP_RESP, 16'hFFFF, '0);
      queue_step(ACT_ITEM, OP_UNUSED, 16'hFFFF, '0);
      // ids 1..3 into slots 0..2, free the middle one, then ask for it again
      repeat (3) queue_step(ACT_ITEM, OP_SEND, 16'hFFFF, '0);
      queue_step(ACT_ITEM, OP_RESP, 16'd2, '0);
      queue_step(ACT_ITEM, OP_RESP, 16'd2, '0);
      // the freed slot is the lowest free one again
      queue_step(ACT_ITEM, OP_SEND, 16'h0000, '0);
      // at the reset limit: three retransmit walks, a timeout walk, an idle tick
      repeat (5) queue_step(ACT_ITEM, OP_TICK, 16'h0000, '0);
      // a zero limit times out everything on the next tick
      queue_step(ACT_CFG, OP_SEND, '0, 4'd0);
      repeat (2) queue_step(ACT_ITEM, OP_SEND, 16'h5A5A, '0);
      repeat (2) queue_step(ACT_ITEM, OP_TICK, 16'hA5A5, '0);

      // Random phases, each under its own limit; high limits let the table fill,
      // the following low ones catch entries above the new limit
      phase_limits = '{4'd15, 4'd1, 4'd0, 4'd9, 4'd15, 4'd3, 4'd7, 4'd1};
      phase_limits[6] = LIMIT_W'($urandom_range(2, 14));
      for (int p = 0; p < 8; p++) begin
         queue_step(ACT_CFG, OP_SEND, '0, phase_limits[p]);
         burst   = (p == 0 || p == 4);
         mix_len = burst ? 14 : 50;
         // overfill the table so that sends are refused
         if (burst) repeat (36) queue_step(ACT_ITEM, OP_SEND, 16'($urandom), '0);
         repeat (mix_len) begin
            r = $urandom_range(0, 99);
            if (r < 30)      queue_step(ACT_ITEM, OP_SEND, 16'($urandom), '0);
            else if (r < 55) queue_step(ACT_LIVE_RESP, OP_RESP, 16'($urandom), '0);
            else if (r < 62) queue_step(ACT_ITEM, OP_RESP, 16'($urandom), '0);
            else if (r < 88) queue_step(ACT_ITEM, OP_TICK, 16'($urandom), '0);
            else if (r < 94) queue_step(ACT_ITEM, OP_UNUSED, 16'($urandom), '0);
            else             queue_step(ACT_DRAIN, OP_SEND, '0, '0);
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // wait for the script to run dry and the block to settle
      do @(negedge clock);
      while (script_q.size() != 0 || req_ch.valid || quiet_cycles < SETTLE);

      if (check_errors == 0) begin
         $display("pending_query_retry_table_tb passed");
      end else begin
         $display("pending_query_retry_table_tb failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/pqrt_pkg.sv
hdl/pqrt_req_if.sv
hdl/pqrt_rsp_if.sv
hdl/pending_query_retry_table.sv
hdl/pqrt_checker.sv
test/pending_query_retry_table_tb.sv
